// ===== hdl/sfd_pkg.sv =====
package sfd_pkg;

    // Frame geometry. An odd frame length rounds down to whole words.
    localparam int FRAME_BYTES = 32;
    localparam int NUM_WORDS   = (FRAME_BYTES - 2) / 2;
    localparam int FRAME_LEN   = 2 * NUM_WORDS + 2;
    localparam int SUM_LEN     = FRAME_LEN - 2;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int INDEX_W = 4;
    localparam int POS_W   = $clog2(FRAME_LEN);
    localparam int IDX_W   = $clog2(NUM_WORDS);

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h42;

    localparam logic [POS_W-1:0] FIRST_HIGH_POS = POS_W'(2);
    localparam logic [POS_W-1:0] FIRST_LOW_POS  = POS_W'(3);
    localparam logic [POS_W-1:0] SUM_END_POS    = POS_W'(SUM_LEN);
    localparam logic [POS_W-1:0] LAST_POS       = POS_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(NUM_WORDS - 1);

    // Control handed from the frame sequencer to the row of word cells.
    typedef struct packed {
        logic              shift;
        logic [WORD_W-1:0] din;
    } chain_ctl_t;

    typedef enum logic [2:0] {
        ST_RECV  = 3'b001,
        ST_WORDS = 3'b010,
        ST_ERROR = 3'b100
    } state_t;

endpackage

// ===== hdl/sensor_frame_deframer_sum16.sv =====
// Latency: the first result is offered in the cycle after the final frame byte is accepted.
// Throughput: one byte per cycle while receiving; a good frame then yields one word per
// cycle while word_ready is high, NUM_WORDS words (the word row shifts once per taken result),
// an error frame one result, and no byte is accepted while results are pending.
// Reset (rst_n, asynchronous, active low) returns the parser to hunting for the start byte;
// the word cells are not reset, since every cell is refilled before a frame reads it.
module sensor_frame_deframer_sum16 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         rx_valid,
    output logic         rx_ready,
    input  logic [7:0]   rx_byte,
    output logic         word_valid,
    input  logic         word_ready,
    output logic [3:0]   word_index,
    output logic [15:0]  word_value,
    output logic         status,
    output logic         last
);

    sfd_pkg::state_t                  state_reg, state_next;
    logic [sfd_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [sfd_pkg::WORD_W-1:0]       sum_reg, sum_next;
    logic [sfd_pkg::BYTE_W-1:0]       hold_reg, hold_next;
    logic [sfd_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [sfd_pkg::WORD_W-1:0]       new_word;
    logic [sfd_pkg::WORD_W-1:0]       tail;
    logic                             rx_fire;
    logic                             word_fire;
    sfd_pkg::chain_ctl_t              chain_ctl;

    assign rx_ready  = (state_reg == sfd_pkg::ST_RECV);
    assign rx_fire   = rx_valid && rx_ready;
    assign word_fire = word_valid && word_ready;

    // The word being completed by the current byte; on the final byte it is
    // the checksum word that the running sum is checked against.
    assign new_word = {hold_reg, rx_byte};

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        idx_next   = idx_reg;
        chain_ctl  = '{shift: 1'b0, din: new_word};

        case (state_reg)
            sfd_pkg::ST_RECV:
            begin
                if (rx_fire)
                begin
                    if (pos_reg == '0)
                    begin
                        // Hunting: anything but the start byte is dropped.
                        if (rx_byte == sfd_pkg::START_BYTE)
                        begin
                            sum_next = {{(sfd_pkg::WORD_W-sfd_pkg::BYTE_W){1'b0}}, rx_byte};
                            pos_next = sfd_pkg::POS_W'(1);
                        end
                    end
                    else
                    begin
                        if (pos_reg < sfd_pkg::SUM_END_POS)
                        begin
                            sum_next = sum_reg
                                     + {{(sfd_pkg::WORD_W-sfd_pkg::BYTE_W){1'b0}}, rx_byte};
                        end
                        if (pos_reg >= sfd_pkg::FIRST_HIGH_POS && !pos_reg[0])
                        begin
                            hold_next = rx_byte;
                        end
                        if (pos_reg >= sfd_pkg::FIRST_LOW_POS && pos_reg[0])
                        begin
                            chain_ctl.shift = 1'b1;
                        end
                        if (pos_reg == sfd_pkg::LAST_POS)
                        begin
                            pos_next = '0;
                            idx_next = '0;
                            if (sum_reg == new_word)
                            begin
                                state_next = sfd_pkg::ST_WORDS;
                            end
                            else
                            begin
                                state_next = sfd_pkg::ST_ERROR;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + sfd_pkg::POS_W'(1);
                        end
                    end
                end
            end
            sfd_pkg::ST_WORDS:
            begin
                if (word_fire)
                begin
                    // Move the next word up to the tail of the row.
                    chain_ctl = '{shift: 1'b1, din: '0};
                    if (idx_reg == sfd_pkg::LAST_IDX)
                    begin
                        state_next = sfd_pkg::ST_RECV;
                    end
                    else
                    begin
                        idx_next = idx_reg + sfd_pkg::IDX_W'(1);
                    end
                end
            end
            sfd_pkg::ST_ERROR:
            begin
                if (word_fire)
                begin
                    state_next = sfd_pkg::ST_RECV;
                end
            end
            default:
            begin
                state_next = sfd_pkg::ST_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfd_pkg::ST_RECV;
            pos_reg   <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            hold_reg  <= hold_next;
            idx_reg   <= idx_next;
        end
    end

    sfd_chain u_chain (
        .clk  (clk),
        .ctl  (chain_ctl),
        .tail (tail)
    );

    // A checksum error carries zero word fields and closes the run at once.
    assign word_valid = (state_reg != sfd_pkg::ST_RECV);
    assign status     = (state_reg == sfd_pkg::ST_ERROR);
    assign word_index = status ? '0 : sfd_pkg::INDEX_W'(idx_reg);
    assign word_value = status ? '0 : tail;
    assign last       = status || (idx_reg == sfd_pkg::LAST_IDX);

`ifndef SYNTHESIS
    a_final_byte_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fire && pos_reg == sfd_pkg::LAST_POS |=> word_valid && !rx_ready)
        else $error("final frame byte did not produce a result");

    a_last_reopens_input: assert property (@(posedge clk) disable iff (!rst_n)
        word_fire && last |=> rx_ready && pos_reg == '0)
        else $error("parser did not return to hunting after last result");

    a_hunt_drops_noise: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fire && pos_reg == '0 && rx_byte != sfd_pkg::START_BYTE |=> pos_reg == '0)
        else $error("non-start byte started a frame");

    a_first_word_index: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && $rose(word_valid) |-> idx_reg == '0)
        else $error("result run did not start at word zero");
`endif

endmodule

// ===== hdl/sfd_cell.sv =====
module sfd_cell (
    input  logic                      clk,
    input  logic                      shift,
    input  logic [sfd_pkg::WORD_W-1:0] din,
    output logic [sfd_pkg::WORD_W-1:0] dout
);

    logic [sfd_pkg::WORD_W-1:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= din;
        end
    end

    assign dout = word_reg;

endmodule

// ===== hdl/sfd_chain.sv =====
module sfd_chain (
    input  logic                       clk,
    input  sfd_pkg::chain_ctl_t        ctl,
    output logic [sfd_pkg::WORD_W-1:0] tail
);

    // Word k of the chain feeds word k+1; the oldest word sits at the tail.
    logic [sfd_pkg::WORD_W-1:0] cell_q [sfd_pkg::NUM_WORDS];

    for (genvar k = 0; k < sfd_pkg::NUM_WORDS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            sfd_cell u_cell (
                .clk   (clk),
                .shift (ctl.shift),
                .din   (ctl.din),
                .dout  (cell_q[k])
            );
        end
        else
        begin : g_body
            sfd_cell u_cell (
                .clk   (clk),
                .shift (ctl.shift),
                .din   (cell_q[k-1]),
                .dout  (cell_q[k])
            );
        end
    end

    assign tail = cell_q[sfd_pkg::NUM_WORDS-1];

endmodule
